@@ hdl/picp_pkg.sv @@
// Shared types and constants for the point-in-convex-polygon unit.
// Depends on nothing; imported by hdl/point_in_convex_polygon_unit.sv.
`default_nettype none

package picp_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_BITS   = 32;
  localparam int IDX_BITS     = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int DET_BITS     = PROD_BITS + 1;

  localparam logic       FUNC_LOAD  = 1'b0;
  localparam logic       FUNC_QUERY = 1'b1;

  localparam logic [1:0] POS_INSIDE   = 2'd0;
  localparam logic [1:0] POS_BOUNDARY = 2'd1;
  localparam logic [1:0] POS_OUTSIDE  = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_V0,
    S_RD_LO,
    S_RD_UP,
    S_CAP_UP,
    S_MUL_A,
    S_MUL_B,
    S_SIGN,
    S_MID_RD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    JOB_EDGE_LO,
    JOB_EDGE_UP,
    JOB_MID,
    JOB_FAR
  } job_t;

endpackage

`default_nettype wire

@@ hdl/point_in_convex_polygon_unit.sv @@
// Point-in-convex-polygon classifier: vertex table, sequencer and one shared
// orientation unit (one 33x33 multiplier and a 67-bit subtractor).
// Depends on hdl/picp_pkg.sv.
// Each query is sequenced through the shared multiplier (two products per orientation)
// and the table read port.
// The block takes no new item while a query is at work.
// Reset clears the control state and sets the vertex count to 3; the table is undefined.
`default_nettype none

module point_in_convex_polygon_unit
  import picp_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_func,
  input  wire logic [9:0]                   in_vertex_index,
  input  wire logic signed [COORD_BITS-1:0] in_coord_x,
  input  wire logic signed [COORD_BITS-1:0] in_coord_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_position_code,
  input  wire logic                         cfg_wr_en,
  input  wire logic [CNT_BITS-1:0]          cfg_wr_data
);

  state_t                state_r, state_nxt;
  job_t                  job_r, job_nxt;
  logic [CNT_BITS-1:0]   count_r;
  logic [IDX_BITS-1:0]   low_r, low_nxt, up_r, up_nxt;
  point_t                q_r, q_nxt, v0_r, v0_nxt, lo_pt_r, lo_pt_nxt, up_pt_r, up_pt_nxt;
  point_t                rdata_r;
  logic [63:0]           vtx_mem_r [MAX_VERTICES];
  logic signed [PROD_BITS-1:0] prod1_r, prod1_nxt, prod2_r, prod2_nxt;
  logic                  pos1_r, pos1_nxt, seg1_r, seg1_nxt;
  logic [1:0]            res_r, res_nxt;
  logic                  out_valid_r;
  logic [1:0]            out_code_r;

  logic                  in_xfer, load_xfer, query_xfer, deliver;
  logic                  rd_en;
  logic [IDX_BITS-1:0]   rd_addr, mid, up_init;
  logic [CNT_BITS-1:0]   n_clamp;
  logic [IDX_BITS:0]     mid_sum;
  point_t                oa, ob;
  logic signed [DIFF_BITS-1:0] mul_a, mul_b;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [DET_BITS-1:0]  det;
  logic                  or_neg, or_zero, or_pos, seg_now;

  function automatic logic in_box(point_t a, point_t b, point_t c);
    logic signed [COORD_BITS-1:0] xl, xh, yl, yh;
    xl = (a.x < b.x) ? a.x : b.x;
    xh = (a.x < b.x) ? b.x : a.x;
    yl = (a.y < b.y) ? a.y : b.y;
    yh = (a.y < b.y) ? b.y : a.y;
    return (xl <= c.x) && (c.x <= xh) && (yl <= c.y) && (c.y <= yh);
  endfunction

  assign in_xfer    = in_valid && !in_stall;
  assign load_xfer  = in_xfer && (in_func == FUNC_LOAD);
  assign query_xfer = in_xfer && (in_func == FUNC_QUERY);
  assign deliver    = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    if (count_r < CNT_BITS'(3)) begin
      n_clamp = CNT_BITS'(3);
    end else if (count_r > CNT_BITS'(MAX_VERTICES)) begin
      n_clamp = CNT_BITS'(MAX_VERTICES);
    end else begin
      n_clamp = count_r;
    end
  end
  assign up_init = IDX_BITS'(n_clamp - CNT_BITS'(1));

  assign mid_sum = {1'b0, up_r} + {1'b0, low_r};
  assign mid     = mid_sum[IDX_BITS:1];

  always_comb begin
    unique case (job_r)
      JOB_EDGE_LO: begin oa = v0_r;    ob = lo_pt_r; end
      JOB_EDGE_UP: begin oa = v0_r;    ob = up_pt_r; end
      JOB_MID:     begin oa = v0_r;    ob = rdata_r; end
      JOB_FAR:     begin oa = lo_pt_r; ob = up_pt_r; end
      default:     begin oa = v0_r;    ob = lo_pt_r; end
    endcase
  end

  always_comb begin
    if (state_r == S_MUL_B) begin
      mul_a = DIFF_BITS'(ob.y) - DIFF_BITS'(oa.y);
      mul_b = DIFF_BITS'(q_r.x) - DIFF_BITS'(oa.x);
    end else begin
      mul_a = DIFF_BITS'(ob.x) - DIFF_BITS'(oa.x);
      mul_b = DIFF_BITS'(q_r.y) - DIFF_BITS'(oa.y);
    end
  end
  assign prod = mul_a * mul_b;

  assign det     = DET_BITS'(prod1_r) - DET_BITS'(prod2_r);
  assign or_neg  = det[DET_BITS-1];
  assign or_zero = (det == '0);
  assign or_pos  = !or_neg && !or_zero;
  assign seg_now = or_zero && in_box(oa, ob, q_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (query_xfer) state_nxt = S_RD_V0;
      S_RD_V0:  state_nxt = S_RD_LO;
      S_RD_LO:  state_nxt = S_RD_UP;
      S_RD_UP:  state_nxt = S_CAP_UP;
      S_CAP_UP: state_nxt = S_MUL_A;
      S_MUL_A:  state_nxt = S_MUL_B;
      S_MUL_B:  state_nxt = S_SIGN;
      S_MID_RD: state_nxt = S_MUL_A;
      S_SIGN: begin
        unique case (job_r)
          JOB_EDGE_LO: state_nxt = S_MUL_A;
          JOB_EDGE_UP: begin
            if (seg1_r || seg_now || !(pos1_r && or_neg)) begin
              state_nxt = S_DONE;
            end else if (up_r - low_r == IDX_BITS'(1)) begin
              state_nxt = S_MUL_A;
            end else begin
              state_nxt = S_MID_RD;
            end
          end
          JOB_MID: begin
            if ((or_pos ? (up_r - mid) : (mid - low_r)) == IDX_BITS'(1)) begin
              state_nxt = S_MUL_A;
            end else begin
              state_nxt = S_MID_RD;
            end
          end
          JOB_FAR: state_nxt = S_DONE;
          default: state_nxt = S_DONE;
        endcase
      end
      S_DONE:   if (deliver) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != S_IDLE);
    rd_en    = 1'b0;
    rd_addr  = '0;
    unique case (state_r)
      S_RD_V0:  begin rd_en = 1'b1; rd_addr = '0; end
      S_RD_LO:  begin rd_en = 1'b1; rd_addr = IDX_BITS'(1); end
      S_RD_UP:  begin rd_en = 1'b1; rd_addr = up_r; end
      S_MID_RD: begin rd_en = 1'b1; rd_addr = mid; end
      default:  begin rd_en = 1'b0; rd_addr = '0; end
    endcase
  end

  always_comb begin
    job_nxt   = job_r;
    low_nxt   = low_r;
    up_nxt    = up_r;
    q_nxt     = q_r;
    v0_nxt    = v0_r;
    lo_pt_nxt = lo_pt_r;
    up_pt_nxt = up_pt_r;
    prod1_nxt = prod1_r;
    prod2_nxt = prod2_r;
    pos1_nxt  = pos1_r;
    seg1_nxt  = seg1_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (query_xfer) begin
          q_nxt   = '{x: in_coord_x, y: in_coord_y};
          low_nxt = IDX_BITS'(1);
          up_nxt  = up_init;
          job_nxt = JOB_EDGE_LO;
        end
      end
      S_RD_LO:  v0_nxt    = rdata_r;
      S_RD_UP:  lo_pt_nxt = rdata_r;
      S_CAP_UP: up_pt_nxt = rdata_r;
      S_MUL_A:  prod1_nxt = prod;
      S_MUL_B:  prod2_nxt = prod;
      S_MID_RD: job_nxt   = JOB_MID;
      S_SIGN: begin
        unique case (job_r)
          JOB_EDGE_LO: begin
            pos1_nxt = or_pos;
            seg1_nxt = seg_now;
            job_nxt  = JOB_EDGE_UP;
          end
          JOB_EDGE_UP: begin
            job_nxt = JOB_FAR;
            if (seg1_r || seg_now) begin
              res_nxt = POS_BOUNDARY;
            end else begin
              res_nxt = POS_OUTSIDE;
            end
          end
          JOB_MID: begin
            job_nxt = JOB_FAR;
            if (or_pos) begin
              low_nxt   = mid;
              lo_pt_nxt = rdata_r;
            end else begin
              up_nxt    = mid;
              up_pt_nxt = rdata_r;
            end
          end
          JOB_FAR: begin
            if (seg_now) begin
              res_nxt = POS_BOUNDARY;
            end else if (or_pos) begin
              res_nxt = POS_INSIDE;
            end else begin
              res_nxt = POS_OUTSIDE;
            end
          end
          default: res_nxt = POS_OUTSIDE;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_xfer) begin
      vtx_mem_r[in_vertex_index] <= {in_coord_x, in_coord_y};
    end
    if (rd_en) begin
      rdata_r <= vtx_mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= JOB_EDGE_LO;
      count_r     <= CNT_BITS'(3);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      out_valid_r <= deliver || (out_valid_r && out_stall);
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    low_r   <= low_nxt;
    up_r    <= up_nxt;
    q_r     <= q_nxt;
    v0_r    <= v0_nxt;
    lo_pt_r <= lo_pt_nxt;
    up_pt_r <= up_pt_nxt;
    prod1_r <= prod1_nxt;
    prod2_r <= prod2_nxt;
    pos1_r  <= pos1_nxt;
    seg1_r  <= seg1_nxt;
    res_r   <= res_nxt;
    if (deliver) begin
      out_code_r <= res_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_position_code = out_code_r;

  // Whenever a midpoint is read, the search interval keeps at least one vertex strictly between its ends.
  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MID_RD) |-> (low_r < up_r) && (up_r - low_r != IDX_BITS'(1)))
    else $error("search interval collapsed");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MID_RD) |-> ({1'b0, up_r} <= n_clamp - CNT_BITS'(1)))
    else $error("search bound beyond vertex count");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    query_xfer |=> (state_r == S_RD_V0) && (job_r == JOB_EDGE_LO))
    else $error("query transfer did not start the sequence");

  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    deliver |=> out_valid_r && (out_code_r != 2'd3))
    else $error("illegal position code delivered");

endmodule

`default_nettype wire
